/* hdl/csd_pkg.sv */
package csd_pkg;

  localparam int REG_BITS = 16;
  localparam int ROW_BITS = 10;
  localparam int CFG_INDEX_BITS = 3;

  // Parse phases of the span stream.
  localparam logic [1:0] PH_OFFSET     = 2'd0;
  localparam logic [1:0] PH_LENGTH     = 2'd1;
  localparam logic [1:0] PH_LENGTH_EXT = 2'd2;
  localparam logic [1:0] PH_PIXELS     = 2'd3;

  localparam logic [7:0] BYTE_EMPTY_ROW = 8'hFF;
  localparam logic [7:0] BYTE_LEN_EXT   = 8'hFE;

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_LIMIT   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_LIMIT    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_RIGHT   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_BOTTOM  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_ROW    = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROWS_ENCODED = 3'd7;

  localparam logic [REG_BITS-1:0] CLIP_RIGHT_RESET  = 16'd640;
  localparam logic [REG_BITS-1:0] CLIP_BOTTOM_RESET = 16'd480;

  typedef struct packed {
    logic [REG_BITS-1:0] origin_x;
    logic [REG_BITS-1:0] origin_y;
    logic [REG_BITS-1:0] left_limit;
    logic [REG_BITS-1:0] top_limit;
    logic [REG_BITS-1:0] clip_right;
    logic [REG_BITS-1:0] clip_bottom;
    logic [ROW_BITS-1:0] first_row_offset;
    logic [ROW_BITS-1:0] rows_encoded;
  } cfg_regs_t;

endpackage

/* hdl/csd_cfg.sv */
module csd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [csd_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  logic [csd_pkg::REG_BITS-1:0]        wr_data,
  output csd_pkg::cfg_regs_t                  regs
);
  import csd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_x         <= '0;
      regs.origin_y         <= '0;
      regs.left_limit       <= '0;
      regs.top_limit        <= '0;
      regs.clip_right       <= CLIP_RIGHT_RESET;
      regs.clip_bottom      <= CLIP_BOTTOM_RESET;
      regs.first_row_offset <= '0;
      regs.rows_encoded     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ORIGIN_X:     regs.origin_x         <= wr_data;
        REG_ORIGIN_Y:     regs.origin_y         <= wr_data;
        REG_LEFT_LIMIT:   regs.left_limit       <= wr_data;
        REG_TOP_LIMIT:    regs.top_limit        <= wr_data;
        REG_CLIP_RIGHT:   regs.clip_right       <= wr_data;
        REG_CLIP_BOTTOM:  regs.clip_bottom      <= wr_data;
        REG_FIRST_ROW:    regs.first_row_offset <= wr_data[ROW_BITS-1:0];
        REG_ROWS_ENCODED: regs.rows_encoded     <= wr_data[ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/csd_parse.sv */
module csd_parse #(
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             stream_byte,
  input  logic                   image_start,
  input  csd_pkg::cfg_regs_t     regs,
  output logic                   emit,
  output logic [COORD_BITS-1:0]  pixel_x,
  output logic [COORD_BITS-1:0]  pixel_y
);
  import csd_pkg::*;

  localparam int WB = COORD_BITS + 12;

  logic [1:0]          phase;
  logic [ROW_BITS-1:0] row_number;
  logic [7:0]          span_start;
  logic [7:0]          span_size;
  logic [7:0]          pixel_position;
  logic                finished;

  logic [1:0]          phase_next;
  logic [ROW_BITS-1:0] row_number_next;
  logic [7:0]          span_start_next;
  logic [7:0]          span_size_next;
  logic [7:0]          pixel_position_next;
  logic                finished_next;

  // State as seen by this byte, after a possible image restart.
  logic [1:0]          cur_phase;
  logic [ROW_BITS-1:0] cur_row;
  logic [7:0]          cur_start;
  logic [7:0]          cur_size;
  logic [7:0]          cur_pos;
  logic                cur_finished;

  logic [REG_BITS+COORD_BITS-1:0] ext_ox, ext_oy, ext_cl, ext_ct, ext_cr, ext_cb;
  logic signed [WB-1:0] ox, oy, cl, ct, cr, cb;
  logic signed [WB-1:0] x_wide, y_wide;
  logic [7:0]           pos_inc;
  logic [7:0]           len_byte;
  logic                 len_valid;

  // Registers are kept at 16 bits and read as COORD_BITS-wide signed values.
  assign ext_ox = {{COORD_BITS{1'b0}}, regs.origin_x};
  assign ext_oy = {{COORD_BITS{1'b0}}, regs.origin_y};
  assign ext_cl = {{COORD_BITS{1'b0}}, regs.left_limit};
  assign ext_ct = {{COORD_BITS{1'b0}}, regs.top_limit};
  assign ext_cr = {{COORD_BITS{1'b0}}, regs.clip_right};
  assign ext_cb = {{COORD_BITS{1'b0}}, regs.clip_bottom};

  assign ox = {{(WB-COORD_BITS){ext_ox[COORD_BITS-1]}}, ext_ox[COORD_BITS-1:0]};
  assign oy = {{(WB-COORD_BITS){ext_oy[COORD_BITS-1]}}, ext_oy[COORD_BITS-1:0]};
  assign cl = {{(WB-COORD_BITS){ext_cl[COORD_BITS-1]}}, ext_cl[COORD_BITS-1:0]};
  assign ct = {{(WB-COORD_BITS){ext_ct[COORD_BITS-1]}}, ext_ct[COORD_BITS-1:0]};
  assign cr = {{(WB-COORD_BITS){ext_cr[COORD_BITS-1]}}, ext_cr[COORD_BITS-1:0]};
  assign cb = {{(WB-COORD_BITS){ext_cb[COORD_BITS-1]}}, ext_cb[COORD_BITS-1:0]};

  always_comb begin
    if (image_start) begin
      cur_phase    = PH_OFFSET;
      cur_row      = '0;
      cur_start    = '0;
      cur_size     = '0;
      cur_pos      = '0;
      cur_finished = 1'b0;
    end else begin
      cur_phase    = phase;
      cur_row      = row_number;
      cur_start    = span_start;
      cur_size     = span_size;
      cur_pos      = pixel_position;
      cur_finished = finished;
    end
  end

  assign x_wide = ox + WB'(cur_start) + WB'(cur_pos);
  assign y_wide = oy + WB'(regs.first_row_offset) + WB'(cur_row);
  assign pos_inc = cur_pos + 8'd1;
  assign pixel_x = x_wide[COORD_BITS-1:0];
  assign pixel_y = y_wide[COORD_BITS-1:0];

  always_comb begin
    phase_next          = cur_phase;
    row_number_next     = cur_row;
    span_start_next     = cur_start;
    span_size_next      = cur_size;
    pixel_position_next = cur_pos;
    finished_next       = cur_finished;
    emit                = 1'b0;
    len_valid           = 1'b0;
    len_byte            = stream_byte;

    if (!cur_finished) begin
      unique case (cur_phase)
        PH_OFFSET: begin
          if (cur_row >= regs.rows_encoded || y_wide >= cb) begin
            finished_next = 1'b1;
          end else if (stream_byte == BYTE_EMPTY_ROW) begin
            row_number_next     = cur_row + 1'b1;
            pixel_position_next = '0;
          end else begin
            span_start_next = stream_byte;
            phase_next      = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (stream_byte == BYTE_LEN_EXT) begin
            phase_next = PH_LENGTH_EXT;
          end else begin
            len_valid = 1'b1;
          end
        end
        PH_LENGTH_EXT: begin
          len_valid = 1'b1;
        end
        PH_PIXELS: begin
          emit = (stream_byte != 8'd0) && (x_wide >= cl) && (x_wide < cr) &&
                 (y_wide >= ct) && (y_wide < cb);
          pixel_position_next = pos_inc;
          if (pos_inc >= cur_size) begin
            row_number_next     = cur_row + 1'b1;
            phase_next          = PH_OFFSET;
            pixel_position_next = '0;
          end
        end
        default: phase_next = PH_OFFSET;
      endcase

      // Open a span; an empty one closes the row right away.
      if (len_valid) begin
        span_size_next      = len_byte;
        pixel_position_next = '0;
        if (len_byte == 8'd0) begin
          row_number_next = cur_row + 1'b1;
          phase_next      = PH_OFFSET;
        end else begin
          phase_next = PH_PIXELS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_OFFSET;
      row_number     <= '0;
      span_start     <= '0;
      span_size      <= '0;
      pixel_position <= '0;
      finished       <= 1'b1;
    end else if (step) begin
      phase          <= phase_next;
      row_number     <= row_number_next;
      span_start     <= span_start_next;
      span_size      <= span_size_next;
      pixel_position <= pixel_position_next;
      finished       <= finished_next;
    end
  end

endmodule

/* hdl/clipped_span_sprite_decoder.sv */
// Clipped span sprite decoder. Feed the span stream of a run-length encoded
// sprite one byte per word on the s_ side, with s_tuser set on the first byte
// of each sprite; bytes before the first such mark are dropped. Each encoded
// row is 0xFF (empty) or an offset byte, a length byte (0xFE escapes to a
// following length byte) and that many pixel bytes. Every non-zero pixel that
// falls inside the clip window (left/top inclusive, right/bottom exclusive)
// leaves as one m_ word with its screen x, screen y and color; all other
// bytes give no word. A sprite ends after rows_encoded rows or when a row
// starts at or below clip_bottom. The block takes one byte per clock while no
// output word stalls: a byte is held in an input register, decoded and clipped
// in one pass of compares and adds, and lands in an output register that
// drives m_tvalid. While an output word stalls, one more byte waits in the
// input register and then s_tready drops. Write the configuration registers
// over cfg_* only while no byte is in flight; cfg_ready is always high.
module clipped_span_sprite_decoder #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [csd_pkg::REG_BITS-1:0]        cfg_data,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] stream_byte
  input  logic [0:0]                          s_tuser,   // [0] image_start
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pixel_x, pixel_y, pixel_color from the low bit up, zero padded
  output logic [((2*COORD_BITS+8+7)/8)*8-1:0] m_tdata
);
  import csd_pkg::*;

  localparam int DATA_W = ((2*COORD_BITS+8+7)/8)*8;
  localparam int PAD_W  = DATA_W - 2*COORD_BITS - 8;

  cfg_regs_t regs;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       out_free;
  logic       step;

  logic                  emit;
  logic [COORD_BITS-1:0] calc_x;
  logic [COORD_BITS-1:0] calc_y;

  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [7:0]            pixel_color;

  assign cfg_ready = 1'b1;

  csd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  // The output register is free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register: hold the byte until the decode stage can advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (out_free) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser[0];
    end
  end

  csd_parse #(
    .COORD_BITS (COORD_BITS)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .stream_byte (in_byte),
    .image_start (in_start),
    .regs        (regs),
    .emit        (emit),
    .pixel_x     (calc_x),
    .pixel_y     (calc_y)
  );

  // Output register: load a visible pixel, otherwise drop the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      pixel_x     <= calc_x;
      pixel_y     <= calc_y;
      pixel_color <= in_byte;
    end
  end

  generate
    if (PAD_W > 0) begin : g_pad
      assign m_tdata = {{PAD_W{1'b0}}, pixel_color, pixel_y, pixel_x};
    end else begin : g_nopad
      assign m_tdata = {pixel_color, pixel_y, pixel_x};
    end
  endgenerate

  // A transparent pixel never leaves the block.
  a_color_opaque: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pixel_color != 8'd0))
    else $error("transparent pixel emitted");

  // Input stalls only when a byte is held behind a stalled output word.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without cause");

  // A word appears only from a byte that was decoded in the previous cycle.
  a_word_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid))
    else $error("output word without a decoded byte");

  // Reset leaves the output empty.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule
